>>> rtl/local_binary_pattern_3x3_top_macros.svh
// assertion macros shared by the checker
`ifndef LOCAL_BINARY_PATTERN_3X3_TOP_MACROS_SVH
`define LOCAL_BINARY_PATTERN_3X3_TOP_MACROS_SVH

// checked only outside reset
`define LBP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked during reset as well
`define LBP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> rtl/lbp_pkg.sv
package lbp_pkg;

  parameter int PIXEL_BITS      = 8;
  parameter int CODE_BITS       = 8;
  parameter int WIDTH_REG_BITS  = 11;
  parameter int HEIGHT_REG_BITS = 13;
  parameter int MAX_WIDTH_DEF   = 1024;
  parameter int QUEUE_DEPTH     = 4;
  parameter int LEVEL_BITS      = $clog2(QUEUE_DEPTH + 1);
  parameter int APB_ADDR_BITS   = 3;
  parameter int APB_DATA_BITS   = 32;

  // register index, taken from paddr[2]
  parameter logic REG_FRAME_WIDTH  = 1'b0;
  parameter logic REG_FRAME_HEIGHT = 1'b1;

  parameter logic [WIDTH_REG_BITS-1:0]  FRAME_WIDTH_RST  = WIDTH_REG_BITS'(1024);
  parameter logic [HEIGHT_REG_BITS-1:0] FRAME_HEIGHT_RST = HEIGHT_REG_BITS'(1);

  // neighbour weights, row-major, centre carries none
  parameter logic [CODE_BITS-1:0] LBP_WEIGHT [9] = '{
    8'd1, 8'd2, 8'd4, 8'd8, 8'd0, 8'd16, 8'd32, 8'd64, 8'd128
  };

  typedef logic [PIXEL_BITS-1:0] pixel_t;

  typedef struct packed {
    logic   req_type;
    pixel_t pixel_value;
  } lbp_in_t;

  typedef struct packed {
    logic [CODE_BITS-1:0] pattern_code;
    logic                 frame_last;
  } lbp_out_t;

  typedef struct packed {
    logic top;
    logic bottom;
    logic left;
    logic right;
  } edge_mask_t;

  typedef struct packed {
    pixel_t [8:0] win;
    edge_mask_t   mask;
    logic         last;
  } lbp_job_t;

endpackage

>>> rtl/local_binary_pattern_3x3_top.sv
// 3x3 local binary pattern over a raster pixel stream
//
// input channel (in_valid_i / in_stall_o / in_data_i): one word per pixel,
// req_type low carries pixel_value, req_type high is a drain word. a code
// belongs to the pixel width+1 words earlier, so width+1 drain words after
// the last pixel of a frame flush the remaining codes. drain words sent
// before the frame is complete are swallowed without effect.
// output channel (out_valid_o / out_stall_i / out_data_o): one word per
// code, frame_last marks the final pixel; the frame counters then wrap.
// apb port: frame_width at 0x0, frame_height at 0x4, to be written only
// while idle, not enforced by the block; any write restarts the frame.
// throughput: one word per cycle in both directions while neither side
// stalls. a code passes the store read stage, then the job queue, into
// the output register.
// out_stall_i fills the four-deep job queue; in_stall_o rises once the
// queue plus the word in the store stage reach four.
// reset clears counters, window and valids; the line stores are not
// cleared, unwritten entries only ever reach masked neighbours.
module local_binary_pattern_3x3_top #(
  parameter int MAX_WIDTH = lbp_pkg::MAX_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // pixel words in
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  lbp_pkg::lbp_in_t                    in_data_i,
  // code words out
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output lbp_pkg::lbp_out_t                   out_data_o,
  // register port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lbp_pkg::APB_ADDR_BITS-1:0]   paddr,
  input  logic [lbp_pkg::APB_DATA_BITS-1:0]   pwdata,
  output logic [lbp_pkg::APB_DATA_BITS-1:0]   prdata,
  output logic                                pready
);

  logic [lbp_pkg::WIDTH_REG_BITS-1:0]  frame_width_q;
  logic [lbp_pkg::HEIGHT_REG_BITS-1:0] frame_height_q;
  logic                                cfg_wr;

  logic                            push, pop, job_valid;
  lbp_pkg::lbp_job_t               job_in, job_out;
  logic [lbp_pkg::LEVEL_BITS-1:0]  queue_level;

  // register port, zero wait states
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= lbp_pkg::FRAME_WIDTH_RST;
      frame_height_q <= lbp_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        lbp_pkg::REG_FRAME_WIDTH: begin
          frame_width_q <= pwdata[lbp_pkg::WIDTH_REG_BITS-1:0];
        end
        lbp_pkg::REG_FRAME_HEIGHT: begin
          frame_height_q <= pwdata[lbp_pkg::HEIGHT_REG_BITS-1:0];
        end
        default: begin
          frame_width_q <= frame_width_q;
        end
      endcase
    end
  end

  // readback, upper bits zero
  always_comb begin
    case (paddr[2])
      lbp_pkg::REG_FRAME_WIDTH:  prdata = lbp_pkg::APB_DATA_BITS'(frame_width_q);
      lbp_pkg::REG_FRAME_HEIGHT: prdata = lbp_pkg::APB_DATA_BITS'(frame_height_q);
      default:                   prdata = '0;
    endcase
  end

  // front: position tracking, line stores and window
  lbp_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .frame_width_i  (frame_width_q),
    .frame_height_i (frame_height_q),
    .restart_i      (cfg_wr),
    .in_valid_i     (in_valid_i),
    .in_data_i      (in_data_i),
    .in_stall_o     (in_stall_o),
    .queue_level_i  (queue_level),
    .push_o         (push),
    .job_o          (job_in)
  );

  // job queue between the two halves
  lbp_fifo #(
    .WIDTH ($bits(lbp_pkg::lbp_job_t)),
    .DEPTH (lbp_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .pop_i   (pop),
    .valid_o (job_valid),
    .data_o  (job_out),
    .level_o (queue_level)
  );

  // back: compares and the output register
  lbp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job_out),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> rtl/lbp_ram.sv
module lbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

>>> rtl/lbp_fifo.sv
module lbp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           data_i,
  input  logic                       pop_i,
  output logic                       valid_o,
  output logic [WIDTH-1:0]           data_o,
  output logic [$clog2(DEPTH+1)-1:0] level_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LVL_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [LVL_W-1:0] level_q, level_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    level_d  = level_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      level_d = level_q + LVL_W'(1);
    end else if (pop_i && !push_i) begin
      level_d = level_q - LVL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign valid_o = (level_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign level_o = level_q;

endmodule

>>> rtl/lbp_front.sv
module lbp_front #(
  parameter int MAX_WIDTH = lbp_pkg::MAX_WIDTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [lbp_pkg::WIDTH_REG_BITS-1:0]   frame_width_i,
  input  logic [lbp_pkg::HEIGHT_REG_BITS-1:0]  frame_height_i,
  input  logic                                 restart_i,
  input  logic                                 in_valid_i,
  input  lbp_pkg::lbp_in_t                     in_data_i,
  output logic                                 in_stall_o,
  input  logic [lbp_pkg::LEVEL_BITS-1:0]       queue_level_i,
  output logic                                 push_o,
  output lbp_pkg::lbp_job_t                    job_o
);

  localparam int COL_W  = $clog2(MAX_WIDTH + 1);
  localparam int ADDR_W = $clog2(MAX_WIDTH);
  localparam int LAG_W  = $clog2(MAX_WIDTH + 2);
  // one spare bit: flushing words run the input row past the last one
  localparam int ROW_W  = lbp_pkg::HEIGHT_REG_BITS + 1;
  localparam int LVL_W  = lbp_pkg::LEVEL_BITS + 1;

  logic [COL_W-1:0] eff_w, w_m1;
  logic [ROW_W-1:0] eff_h, h_m1;

  logic [COL_W-1:0] in_col_q, in_col_d, out_col_q, out_col_d;
  logic [ROW_W-1:0] in_row_q, in_row_d, out_row_q, out_row_d;
  logic [LAG_W-1:0] lag_q, lag_d;

  logic in_frame, active, accept, step, emit, last_a, b_pend;
  lbp_pkg::pixel_t     bot_a;
  lbp_pkg::edge_mask_t mask_a;

  // second stage: store read data arrives here
  logic                b_valid_q, b_emit_q, b_last_q;
  logic [COL_W-1:0]    b_col_q;
  lbp_pkg::pixel_t     b_bot_q;
  lbp_pkg::edge_mask_t b_mask_q;

  logic            fwd_q, fwd_d;
  lbp_pkg::pixel_t fwd_upper_q, fwd_lower_q;
  lbp_pkg::pixel_t upper_rd, lower_rd, top_b, mid_b;

  lbp_pkg::pixel_t [8:0] win_q, win_d;

  // effective frame size
  always_comb begin
    if (frame_width_i == '0) begin
      eff_w = COL_W'(1);
    end else if (32'(frame_width_i) > 32'(MAX_WIDTH)) begin
      eff_w = COL_W'(MAX_WIDTH);
    end else begin
      eff_w = COL_W'(frame_width_i);
    end
    eff_h = (frame_height_i == '0) ? ROW_W'(1) : ROW_W'(frame_height_i);
    w_m1  = eff_w - COL_W'(1);
    h_m1  = eff_h - ROW_W'(1);
  end

  assign b_pend     = b_valid_q && b_emit_q;
  assign in_stall_o = !((LVL_W'(queue_level_i) + LVL_W'(b_pend))
                        < LVL_W'(lbp_pkg::QUEUE_DEPTH));
  assign accept     = in_valid_i && !in_stall_o;

  // classify: early drains are dropped, surplus pixels count as drains
  assign in_frame = (in_row_q < eff_h);
  assign active   = !(in_data_i.req_type && in_frame);
  assign step     = accept && active;
  assign bot_a    = in_frame ? in_data_i.pixel_value : '0;

  assign emit   = (lag_q > LAG_W'(eff_w));
  assign last_a = (out_row_q == h_m1) && (out_col_q == w_m1);

  assign mask_a.top    = (out_row_q != '0);
  assign mask_a.bottom = (out_row_q < h_m1);
  assign mask_a.left   = (out_col_q != '0);
  assign mask_a.right  = (out_col_q < w_m1);

  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    lag_d     = lag_q;
    if (restart_i) begin
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
      lag_d     = '0;
    end else if (step) begin
      if (in_col_q >= w_m1) begin
        in_col_d = '0;
        in_row_d = in_row_q + ROW_W'(1);
      end else begin
        in_col_d = in_col_q + COL_W'(1);
      end
      if (emit) begin
        if (out_col_q >= w_m1) begin
          out_col_d = '0;
          out_row_d = out_row_q + ROW_W'(1);
        end else begin
          out_col_d = out_col_q + COL_W'(1);
        end
        if (last_a) begin
          in_col_d  = '0;
          in_row_d  = '0;
          out_col_d = '0;
          out_row_d = '0;
          lag_d     = '0;
        end
      end else begin
        lag_d = lag_q + LAG_W'(1);
      end
    end
  end

  // line stores: upper holds two rows back, lower one row back
  lbp_ram #(
    .WIDTH (lbp_pkg::PIXEL_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_upper (
    .clk_i   (clk_i),
    .we_i    (b_valid_q),
    .waddr_i (b_col_q[ADDR_W-1:0]),
    .wdata_i (mid_b),
    .re_i    (step),
    .raddr_i (in_col_q[ADDR_W-1:0]),
    .rdata_o (upper_rd)
  );

  lbp_ram #(
    .WIDTH (lbp_pkg::PIXEL_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_lower (
    .clk_i   (clk_i),
    .we_i    (b_valid_q),
    .waddr_i (b_col_q[ADDR_W-1:0]),
    .wdata_i (b_bot_q),
    .re_i    (step),
    .raddr_i (in_col_q[ADDR_W-1:0]),
    .rdata_o (lower_rd)
  );

  // bypass when a read meets the write of the same column
  assign top_b = fwd_q ? fwd_upper_q : upper_rd;
  assign mid_b = fwd_q ? fwd_lower_q : lower_rd;
  assign fwd_d = step && b_valid_q && (in_col_q == b_col_q);

  always_comb begin
    win_d = win_q;
    if (b_valid_q) begin
      win_d[0] = win_q[1];
      win_d[1] = win_q[2];
      win_d[2] = top_b;
      win_d[3] = win_q[4];
      win_d[4] = win_q[5];
      win_d[5] = mid_b;
      win_d[6] = win_q[7];
      win_d[7] = win_q[8];
      win_d[8] = b_bot_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      lag_q     <= '0;
      b_valid_q <= 1'b0;
      fwd_q     <= 1'b0;
      win_q     <= '0;
    end else begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      lag_q     <= lag_d;
      b_valid_q <= step;
      fwd_q     <= fwd_d;
      win_q     <= win_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      b_emit_q <= emit;
      b_last_q <= last_a;
      b_col_q  <= in_col_q;
      b_bot_q  <= bot_a;
      b_mask_q <= mask_a;
    end
    fwd_upper_q <= mid_b;
    fwd_lower_q <= b_bot_q;
  end

  assign push_o     = b_pend;
  assign job_o.win  = win_d;
  assign job_o.mask = b_mask_q;
  assign job_o.last = b_last_q;

endmodule

>>> rtl/lbp_back.sv
module lbp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  input  lbp_pkg::lbp_job_t job_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output lbp_pkg::lbp_out_t out_data_o
);

  logic                             out_valid_q;
  lbp_pkg::lbp_out_t                out_data_q;
  logic [lbp_pkg::CODE_BITS-1:0]    code;
  logic                             row_ok, col_ok;

  // eight compares against the centre, masked at the frame edge
  always_comb begin
    code = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        row_ok = ((r != 0) || job_i.mask.top) && ((r != 2) || job_i.mask.bottom);
        col_ok = ((c != 0) || job_i.mask.left) && ((c != 2) || job_i.mask.right);
        if (row_ok && col_ok && (job_i.win[r*3+c] > job_i.win[4])) begin
          code = code | lbp_pkg::LBP_WEIGHT[r*3+c];
        end
      end
    end
  end

  assign pop_o = job_valid_i && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_data_q.pattern_code <= code;
      out_data_q.frame_last   <= job_i.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

>>> rtl/lbp_checker.sv
`include "local_binary_pattern_3x3_top_macros.svh"

module lbp_top_props (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input lbp_pkg::lbp_out_t                 out_data_o,
  input logic                              psel,
  input logic                              penable,
  input logic                              pwrite,
  input logic                              pready,
  input logic [lbp_pkg::APB_ADDR_BITS-1:0] paddr,
  input logic [lbp_pkg::APB_DATA_BITS-1:0] pwdata,
  input logic [lbp_pkg::APB_DATA_BITS-1:0] prdata
);

  logic                               out_held, width_wr, width_rd;
  logic [lbp_pkg::WIDTH_REG_BITS-1:0] width_rb, width_wd;

  assign out_held = out_valid_o && out_stall_i;
  assign width_wr = psel && penable && pwrite && pready
                    && (paddr[2] == lbp_pkg::REG_FRAME_WIDTH);
  assign width_rd = psel && !pwrite && (paddr[2] == lbp_pkg::REG_FRAME_WIDTH);
  assign width_rb = prdata[lbp_pkg::WIDTH_REG_BITS-1:0];
  assign width_wd = pwdata[lbp_pkg::WIDTH_REG_BITS-1:0];

  // a stalled code word stays and holds its value
  `LBP_ASSERT(a_out_hold, out_held |=> out_valid_o, "output word dropped")
  `LBP_ASSERT(a_out_stable, out_held |=> $stable(out_data_o), "output word changed")

  // reset clears the output valid by the next edge
  `LBP_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |=> !out_valid_o, "output valid after reset")

  // width written is read back in the next cycle
  `LBP_ASSERT(a_width_rb, width_wr |=> !width_rd || width_rb == $past(width_wd), "width readback")

endmodule

bind local_binary_pattern_3x3_top lbp_top_props u_lbp_top_props (.*);

>>> dv/lbp_checker.sv
`timescale 1ns / 1ps

package lbp_stream_pkg;

  // req_type values of an input word
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

endpackage

module lbp_checker #(
  parameter int MAX_WIDTH = lbp_pkg::MAX_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  lbp_pkg::lbp_in_t                  in_data_i,
  input  logic                              out_valid_i,
  input  logic                              out_stall_i,
  input  lbp_pkg::lbp_out_t                 out_data_i,
  input  logic                              psel_i,
  input  logic                              penable_i,
  input  logic                              pwrite_i,
  input  logic                              pready_i,
  input  logic [lbp_pkg::APB_ADDR_BITS-1:0] paddr_i,
  input  logic [lbp_pkg::APB_DATA_BITS-1:0] pwdata_i,
  output int unsigned                       codes_pending_o,
  output int unsigned                       codes_checked_o,
  output int unsigned                       mismatches_o
);

  import lbp_pkg::*;
  import lbp_stream_pkg::*;

  logic [WIDTH_REG_BITS-1:0]  width_reg;
  logic [HEIGHT_REG_BITS-1:0] height_reg;

  pixel_t      upper_row [MAX_WIDTH];
  pixel_t      lower_row [MAX_WIDTH];
  pixel_t      window_px [9];
  int unsigned in_row, in_col, out_row, out_col;
  lbp_out_t    code_q [$];

  function automatic int unsigned row_len();
    if (width_reg == '0) return 1;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return width_reg;
  endfunction

  function automatic int unsigned row_count();
    return (height_reg == '0) ? 1 : height_reg;
  endfunction

  task automatic restart_counts();
    in_row  = 0;
    in_col  = 0;
    out_row = 0;
    out_col = 0;
  endtask

  // advance the window by one word and queue the code it releases, if any
  task automatic take_word(input lbp_in_t word);
    int unsigned cols, rows, pos, lin, olin, slot, r, c;
    pixel_t      new_px, centre;
    lbp_out_t    code;
    cols = row_len();
    rows = row_count();
    lin  = in_row * cols + in_col;
    // drain before the frame is complete is swallowed
    if (word.req_type == REQ_DRAIN && lin < rows * cols) return;
    new_px = (lin < rows * cols) ? word.pixel_value : '0;
    slot   = (in_col >= MAX_WIDTH) ? MAX_WIDTH - 1 : in_col;
    for (r = 0; r < 3; r++) begin
      window_px[3*r]   = window_px[3*r+1];
      window_px[3*r+1] = window_px[3*r+2];
    end
    window_px[2]    = upper_row[slot];
    window_px[5]    = lower_row[slot];
    window_px[8]    = new_px;
    upper_row[slot] = lower_row[slot];
    lower_row[slot] = new_px;
    in_col++;
    if (in_col >= cols) begin
      in_col = 0;
      in_row++;
    end
    olin = out_row * cols + out_col;
    if (lin >= olin && lin - olin >= cols + 1) begin
      centre            = window_px[4];
      code.pattern_code = '0;
      code.frame_last   = (out_row == rows - 1) && (out_col == cols - 1);
      for (r = 0; r < 3; r++) begin
        for (c = 0; c < 3; c++) begin
          pos = 3 * r + c;
          if (pos == 4) continue;
          if (r == 0 && out_row == 0) continue;
          if (r == 2 && out_row >= rows - 1) continue;
          if (c == 0 && out_col == 0) continue;
          if (c == 2 && out_col >= cols - 1) continue;
          // weights run 1..128 over the neighbours, skipping the centre
          if (window_px[pos] > centre) code.pattern_code[(pos < 4) ? pos : pos - 1] = 1'b1;
        end
      end
      code_q.push_back(code);
      out_col++;
      if (out_col >= cols) begin
        out_col = 0;
        out_row++;
      end
      if (code.frame_last) restart_counts();
    end
  endtask

  task automatic check_code(input lbp_out_t seen);
    lbp_out_t want;
    if (code_q.size() == 0) begin
      $display("%0t: unexpected code word %02h last %0b, none expected",
               $time, seen.pattern_code, seen.frame_last);
      mismatches_o++;
      return;
    end
    want = code_q.pop_front();
    codes_checked_o++;
    if (seen.pattern_code !== want.pattern_code || seen.frame_last !== want.frame_last) begin
      $display("%0t: code mismatch, expected code %02h last %0b, got code %02h last %0b",
               $time, want.pattern_code, want.frame_last, seen.pattern_code, seen.frame_last);
      mismatches_o++;
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      width_reg  = FRAME_WIDTH_RST;
      height_reg = FRAME_HEIGHT_RST;
      foreach (upper_row[i]) begin
        upper_row[i] = '0;
        lower_row[i] = '0;
      end
      foreach (window_px[i]) window_px[i] = '0;
      restart_counts();
      code_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) check_code(out_data_i);
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        if (paddr_i[2] == REG_FRAME_WIDTH) width_reg = pwdata_i[WIDTH_REG_BITS-1:0];
        else height_reg = pwdata_i[HEIGHT_REG_BITS-1:0];
        restart_counts();
      end
      if (in_valid_i && !in_stall_i) take_word(in_data_i);
    end
    codes_pending_o = code_q.size();
  end

endmodule

>>> dv/local_binary_pattern_3x3_top_test.sv
`timescale 1ns / 1ps

module local_binary_pattern_3x3_top_test;

  import lbp_pkg::*;
  import lbp_stream_pkg::*;

  localparam int CLK_PERIOD    = 10;
  localparam int RESET_CYCLES  = 11;
  // store stage, output register and the four-deep job queue
  localparam int SETTLE_CYCLES = 10;
  localparam int QUIET_LIMIT   = 2000;
  localparam int RANDOM_ITEMS  = 800;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_stall_o;
  lbp_in_t                  in_data_i   = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  lbp_out_t                 out_data_o;
  logic                     psel        = 1'b0;
  logic                     penable     = 1'b0;
  logic                     pwrite      = 1'b0;
  logic [APB_ADDR_BITS-1:0] paddr       = '0;
  logic [APB_DATA_BITS-1:0] pwdata      = '0;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;

  int unsigned codes_pending, codes_checked, mismatches;
  idle_mode_e  idle_mode = IDLE_NONE;
  int unsigned words_sent, frame_items, settings_used, quiet_cycles;
  // effective frame size as the block sees it after the last write
  int unsigned cur_w = MAX_WIDTH_DEF, cur_h = 1;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  local_binary_pattern_3x3_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // watches both channels and the register port, predicts and compares
  lbp_checker code_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .in_data_i      (in_data_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_data_i     (out_data_o),
    .psel_i         (psel),
    .penable_i      (penable),
    .pwrite_i       (pwrite),
    .pready_i       (pready),
    .paddr_i        (paddr),
    .pwdata_i       (pwdata),
    .codes_pending_o(codes_pending),
    .codes_checked_o(codes_checked),
    .mismatches_o   (mismatches)
  );

  // idling rates in percent for the current phase
  function automatic int unsigned gap_pct(input idle_mode_e m);
    case (m)
      IDLE_SEND: return 46;
      IDLE_BOTH: return 16;
      default:   return 0;
    endcase
  endfunction

  function automatic int unsigned stall_pct(input idle_mode_e m);
    case (m)
      IDLE_RECV: return 46;
      IDLE_BOTH: return 16;
      default:   return 0;
    endcase
  endfunction

  // receiver back-pressure, redrawn every cycle
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < stall_pct(idle_mode));
  end

  // watchdog: too long without any word or register access moving
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // mix of ties, the extremes and plain random values
  function automatic pixel_t pick_pixel();
    case ($urandom_range(0, 3))
      0:       return pixel_t'($urandom_range(0, 3));
      1:       return $urandom_range(0, 1) ? '1 : '0;
      default: return pixel_t'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic lbp_in_t pixel_word(input pixel_t value);
    lbp_in_t word;
    word.req_type    = REQ_PIXEL;
    word.pixel_value = value;
    return word;
  endfunction

  // pixel field of a drain word is junk, the block must ignore it
  function automatic lbp_in_t drain_word();
    lbp_in_t word;
    word.req_type    = REQ_DRAIN;
    word.pixel_value = pixel_t'($urandom_range(0, 255));
    return word;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_word(input lbp_in_t word);
    while ($urandom_range(0, 99) < gap_pct(idle_mode)) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= word;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
    words_sent++;
  endtask

  // setup then access phase, then an idle spell with psel low so writes never abut
  task automatic write_reg(input logic reg_sel, input logic [APB_DATA_BITS-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  // all released codes back, then let any word still in the store stage settle
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (codes_pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_frame(input int unsigned wreg, input int unsigned hreg);
    wait_idle();
    write_reg(REG_FRAME_WIDTH, APB_DATA_BITS'(wreg));
    write_reg(REG_FRAME_HEIGHT, APB_DATA_BITS'(hreg));
    cur_w = (wreg == 0) ? 1 : ((wreg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : wreg);
    cur_h = (hreg == 0) ? 1 : hreg;
    settings_used++;
  endtask

  // one frame of random pixels followed by width+1 flushing words;
  // noisy frames mix in swallowed drains and surplus pixels as flushers,
  // a non-zero cut stops after that many pixels and leaves the frame open
  task automatic run_frame(input bit noisy, input int unsigned cut);
    int unsigned npix, k;
    npix = cur_w * cur_h;
    if (cut != 0 && cut < npix) npix = cut;
    for (k = 0; k < npix; k++) begin
      if (noisy && $urandom_range(0, 15) == 0) send_word(drain_word());
      send_word(pixel_word(pick_pixel()));
    end
    frame_items += npix;
    if (npix == cur_w * cur_h) begin
      for (k = 0; k <= cur_w; k++) begin
        if (noisy && $urandom_range(0, 2) == 0) send_word(pixel_word(pick_pixel()));
        else send_word(drain_word());
      end
      frame_items += cur_w + 1;
      // a drain right after frame end belongs to the next frame: swallowed
      if (noisy && $urandom_range(0, 1) == 0) send_word(drain_word());
    end
  endtask

  function automatic int unsigned pick_width();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return 1;
      2:       return $urandom_range(17, 40);
      default: return $urandom_range(1, 16);
    endcase
  endfunction

  function automatic int unsigned pick_height();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return 1;
      default: return $urandom_range(2, 6);
    endcase
  endfunction

  initial begin
    pixel_t      ramp [9];
    int unsigned phase, k;

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: 3x3 frame, centre darker than all eight neighbours,
    // a tie on the right edge and a bright corner giving an empty code
    ramp = '{8'd200, 8'd255, 8'd1, 8'd128, 8'd0, 8'd1, 8'd99, 8'd254, 8'd255};
    set_frame(3, 3);
    for (k = 0; k < 9; k++) begin
      if (k == 4) send_word(drain_word());  // early drain, swallowed
      send_word(pixel_word(ramp[k]));
    end
    repeat (3) send_word(drain_word());
    send_word(pixel_word(8'd77));  // surplus pixel flushes the last code
    send_word(drain_word());       // new frame not complete: swallowed

    // zero width and height both count as one: a single pixel frame
    set_frame(0, 0);
    send_word(pixel_word(8'd0));
    send_word(pixel_word(8'd255));
    send_word(drain_word());

    // widest frame: over-range width clamps to the maximum, cut short
    // once the first row of codes is flowing
    idle_mode = IDLE_BOTH;
    set_frame(2047, 2);
    run_frame(1'b1, MAX_WIDTH_DEF + 60);

    // tallest register values, only the top of the frame is visited
    idle_mode = IDLE_SEND;
    set_frame(2, 8191);
    run_frame(1'b1, 60);
    set_frame(1, 4096);
    run_frame(1'b0, 40);

    // random small frames, idling pattern rotating phase by phase
    frame_items = 0;
    phase       = 0;
    while (frame_items < RANDOM_ITEMS) begin
      idle_mode = idle_mode_e'(phase % 4);
      set_frame(pick_width(), pick_height());
      repeat ($urandom_range(1, 4)) run_frame($urandom_range(0, 4) == 0, 0);
      if ($urandom_range(0, 4) == 0) run_frame(1'b1, $urandom_range(1, cur_w * cur_h));
      phase++;
    end

    wait_idle();
    $display("run covered %0d input words over %0d frame settings, %0d codes checked",
             words_sent, settings_used, codes_checked);
    $display("widths 0 to 2047, heights 0 to 8191, swallowed drains, surplus pixels, cut frames");
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/lbp_pkg.sv
rtl/lbp_ram.sv
rtl/lbp_fifo.sv
rtl/lbp_front.sv
rtl/lbp_back.sv
rtl/local_binary_pattern_3x3_top.sv
rtl/lbp_checker.sv
dv/lbp_checker.sv
dv/local_binary_pattern_3x3_top_test.sv
